// ----- rtl/core/irc_tok_pkg.sv -----
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared types and field codes for the IRC line tokenizer.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TAG_W   = 3;
  localparam int unsigned PNUM_W  = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [PNUM_W-1:0] pnum_t;

  // Field tags carried on the result channel
  localparam tag_t TAG_SEP   = 3'd0;
  localparam tag_t TAG_NICK  = 3'd1;
  localparam tag_t TAG_USER  = 3'd2;
  localparam tag_t TAG_HOST  = 3'd3;
  localparam tag_t TAG_CMD   = 3'd4;
  localparam tag_t TAG_MID   = 3'd5;
  localparam tag_t TAG_TRAIL = 3'd6;
  localparam tag_t TAG_EOL   = 3'd7;

  // Characters of interest
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_SP    = 8'h20;
  localparam byte_t CH_HT    = 8'h09;
  localparam byte_t CH_VT    = 8'h0B;
  localparam byte_t CH_FF    = 8'h0C;
  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_BANG  = 8'h21;
  localparam byte_t CH_AT    = 8'h40;
  localparam byte_t CH_LO_A  = 8'h61;
  localparam byte_t CH_LO_Z  = 8'h7A;
  localparam byte_t CASE_OFS = 8'h20;

  typedef struct packed {
    byte_t       data;
    tag_t        tag;
    pnum_t       pnum;
    logic        first;
    logic        done;
    logic        over;
  } tok_res_t;

endpackage

// ----- rtl/core/irc_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Tags each byte of an IRC text stream with the message field it belongs to.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. A byte is captured in an
// input register, tagged by the parser logic and the result is held in an
// output register, so the block takes one byte per clock cycle while the
// result channel does not stall; the only loop is the update of the parser
// state. Back-pressure on the result channel stalls the input register and
// then the input channel. CR or LF ends a line and returns the parser to its
// line-start state.
module irc_line_tokenizer #(
  parameter int MAX_PARAMS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  irc_tok_pkg::byte_t in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output irc_tok_pkg::byte_t out_byte,
  output irc_tok_pkg::tag_t  out_field_tag,
  output irc_tok_pkg::pnum_t out_param_number,
  output logic               out_field_first,
  output logic               out_line_done,
  output logic               out_too_many_params
);
  import irc_tok_pkg::*;

  logic     s1_valid_r;
  byte_t    s1_byte_r;
  logic     s1_adv;
  tok_res_t res;
  tok_res_t res_r;
  logic     out_valid_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  irc_tok_fsm #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .byte_i (s1_byte_r),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = res_r.data;
  assign out_field_tag       = res_r.tag;
  assign out_param_number    = res_r.pnum;
  assign out_field_first     = res_r.first;
  assign out_line_done       = res_r.done;
  assign out_too_many_params = res_r.over;

endmodule

// ----- rtl/core/irc_tok_fsm.sv -----
// ----------------------------------------------------------------------------
// irc_tok_fsm
// Line parser state and the per-byte tagging logic.
// ----------------------------------------------------------------------------
module irc_tok_fsm #(
  parameter int MAX_PARAMS = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  irc_tok_pkg::byte_t    byte_i,
  output irc_tok_pkg::tok_res_t res_o
);
  import irc_tok_pkg::*;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_NICK   = 3'd1,
    PH_USER   = 3'd2,
    PH_HOST   = 3'd3,
    PH_PRECMD = 3'd4,
    PH_CMD    = 3'd5,
    PH_PARAMS = 3'd6,
    PH_TRAIL  = 3'd7
  } phase_t;

  localparam pnum_t MAX_P = PNUM_W'(MAX_PARAMS);

  phase_t phase_r, phase_nxt;
  pnum_t  count_r, count_nxt;
  logic   inside_r, inside_nxt;
  logic   content_r, content_nxt;
  logic   ovf_r, ovf_nxt;

  pnum_t  cnt_open;
  logic   ovf_open;
  logic   blank;
  logic   eol;
  tag_t   tag;
  logic   first;
  logic   use_pnum;

  always_comb begin
    blank = (byte_i == CH_SP) || (byte_i == CH_HT) || (byte_i == CH_VT) ||
            (byte_i == CH_FF);
    eol   = (byte_i == CH_CR) || (byte_i == CH_LF);

    // Effect of starting a new parameter, used only in the parameter phase
    if (count_r < MAX_P) begin
      cnt_open = count_r + 1'b1;
      ovf_open = ovf_r;
    end else begin
      cnt_open = count_r;
      ovf_open = 1'b1;
    end

    phase_nxt   = phase_r;
    count_nxt   = count_r;
    inside_nxt  = inside_r;
    content_nxt = 1'b1;
    ovf_nxt     = ovf_r;
    tag         = TAG_SEP;
    first       = 1'b0;
    use_pnum    = 1'b0;

    if (eol) begin
      phase_nxt   = PH_START;
      count_nxt   = '0;
      inside_nxt  = 1'b0;
      content_nxt = 1'b0;
      ovf_nxt     = 1'b0;
      tag         = TAG_EOL;
    end else begin
      unique case (phase_r)
        PH_START: begin
          if (byte_i == CH_COLON) begin
            phase_nxt  = PH_NICK;
            inside_nxt = 1'b0;
          end else if (blank) begin
            phase_nxt = PH_PRECMD;
          end else begin
            phase_nxt = PH_CMD;
            tag       = TAG_CMD;
            first     = 1'b1;
          end
        end
        PH_NICK: begin
          if (byte_i == CH_BANG) begin
            phase_nxt  = PH_USER;
            inside_nxt = 1'b0;
          end else if (byte_i == CH_SP) begin
            phase_nxt  = PH_PRECMD;
            inside_nxt = 1'b0;
          end else begin
            tag        = TAG_NICK;
            first      = !inside_r;
            inside_nxt = 1'b1;
          end
        end
        PH_USER: begin
          if (byte_i == CH_AT) begin
            phase_nxt  = PH_HOST;
            inside_nxt = 1'b0;
          end else if (byte_i == CH_SP) begin
            phase_nxt  = PH_PRECMD;
            inside_nxt = 1'b0;
          end else begin
            tag        = TAG_USER;
            first      = !inside_r;
            inside_nxt = 1'b1;
          end
        end
        PH_HOST: begin
          if (blank) begin
            phase_nxt  = PH_PRECMD;
            inside_nxt = 1'b0;
          end else begin
            tag        = TAG_HOST;
            first      = !inside_r;
            inside_nxt = 1'b1;
          end
        end
        PH_PRECMD: begin
          if (!blank) begin
            phase_nxt = PH_CMD;
            tag       = TAG_CMD;
            first     = 1'b1;
          end
        end
        PH_CMD: begin
          if (blank) begin
            phase_nxt  = PH_PARAMS;
            inside_nxt = 1'b0;
          end else begin
            tag = TAG_CMD;
          end
        end
        PH_PARAMS: begin
          if (blank) begin
            inside_nxt = 1'b0;
          end else if (!inside_r && (byte_i == CH_COLON)) begin
            count_nxt  = cnt_open;
            ovf_nxt    = ovf_open;
            phase_nxt  = PH_TRAIL;
            inside_nxt = 1'b0;
          end else begin
            if (!inside_r) begin
              count_nxt = cnt_open;
              ovf_nxt   = ovf_open;
              first     = 1'b1;
            end
            inside_nxt = 1'b1;
            tag        = TAG_MID;
            use_pnum   = 1'b1;
          end
        end
        PH_TRAIL: begin
          tag        = TAG_TRAIL;
          first      = !inside_r;
          inside_nxt = 1'b1;
          use_pnum   = 1'b1;
        end
      endcase
    end

    res_o.data  = byte_i;
    if ((tag == TAG_CMD) && (byte_i >= CH_LO_A) && (byte_i <= CH_LO_Z)) begin
      res_o.data = byte_i - CASE_OFS;
    end
    res_o.tag   = tag;
    res_o.first = first;
    // Parameter index is the count after this byte, less one
    res_o.pnum  = (use_pnum && (count_nxt != '0)) ? (count_nxt - 1'b1) : '0;
    res_o.done  = eol && content_r;
    res_o.over  = eol ? ovf_r : ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      count_r   <= '0;
      inside_r  <= 1'b0;
      content_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      inside_r  <= inside_nxt;
      content_r <= content_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule
